@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL.
// The checking forms are compiled in simulation; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent property, sampled on the rising clock, off while reset is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ src/nps_pkg.sv @@
`timescale 1ns / 1ps

package nps_pkg;

  localparam int NUM_REFERENCES   = 14;
  localparam int MAX_ENTRIES      = 256;
  localparam int NUM_TABLE_COLORS = 14;

  localparam int CHAN_W = 16;  // one color channel
  localparam int SQ_W   = 32;  // square of a channel difference
  localparam int DIST_W = 34;  // sum of three squares
  localparam int PIX_W  = 8;   // pixel index as reported
  localparam int REFN_W = 4;   // reference number as reported

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  localparam rgb_t REF_COLORS [NUM_TABLE_COLORS] = '{
    '{16'd61166, 16'd61166, 16'd56797},
    '{16'd34952, 16'd34952, 16'd34952},
    '{16'd0,     16'd0,     16'd0    },
    '{16'd65535, 16'd65535, 16'd0    },
    '{16'd48059, 16'd48059, 16'd48059},
    '{16'd21845, 16'd21845, 16'd21845},
    '{16'd65535, 16'd65535, 16'd65535},
    '{16'd65535, 16'd0,     16'd0    },
    '{16'd0,     16'd65535, 16'd0    },
    '{16'd0,     16'd0,     16'd65535},
    '{16'd65535, 16'd65535, 16'd48059},
    '{16'd56797, 16'd0,     16'd0    },
    '{16'd0,     16'd48059, 16'd0    },
    '{16'd0,     16'd0,     16'd52428}
  };

  // Entry as it travels down the cell chain.
  typedef struct packed {
    logic             cand;  // a valid entry that competes
    logic             last;  // a valid entry that closes the run
    rgb_t             color;
    logic [PIX_W-1:0] pix;
  } entry_t;

  // Unload control broadcast to every cell.
  typedef struct packed {
    logic shift;  // move best pixels one cell toward the head
    logic clear;  // back to the empty state
  } ctrl_t;

endpackage

@@ src/nps_cell.sv @@
`timescale 1ns / 1ps

module nps_cell #(
  parameter int REF_IDX = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nps_pkg::entry_t             entry_i,
  input  nps_pkg::ctrl_t              ctrl_i,
  input  logic [nps_pkg::PIX_W-1:0]   pix_right_i,
  output nps_pkg::entry_t             entry_o,
  output logic [nps_pkg::PIX_W-1:0]   pix_o,
  output logic                        done_o
);

  localparam int TabIdx = REF_IDX % nps_pkg::NUM_TABLE_COLORS;
  localparam nps_pkg::rgb_t RefColor = nps_pkg::REF_COLORS[TabIdx];
  localparam int DW = nps_pkg::DIST_W;

  function automatic logic [nps_pkg::SQ_W-1:0] sq_diff(
    input logic [nps_pkg::CHAN_W-1:0] a,
    input logic [nps_pkg::CHAN_W-1:0] b
  );
    logic [nps_pkg::CHAN_W-1:0] d;
    logic [nps_pkg::SQ_W-1:0]   p;
    d = (a >= b) ? (a - b) : (b - a);
    p = d * d;
    return p;
  endfunction

  // forwarded entry
  logic                      fwd_cand_q, fwd_last_q;
  nps_pkg::rgb_t             fwd_color_q;
  logic [nps_pkg::PIX_W-1:0] fwd_pix_q;

  // stage A: squared channel differences
  logic [nps_pkg::SQ_W-1:0]  sq_r_q, sq_g_q, sq_b_q;
  logic [nps_pkg::PIX_W-1:0] pix_a_q;
  logic                      cand_a_q, last_a_q;

  // stage B: running best
  logic [DW-1:0]             best_dist_q, best_dist_d;
  logic [nps_pkg::PIX_W-1:0] best_pix_q, best_pix_d;
  logic                      done_q;
  logic [DW-1:0]             cur_dist;

  assign cur_dist = DW'(sq_r_q) + DW'(sq_g_q) + DW'(sq_b_q);

  always_comb begin
    best_dist_d = best_dist_q;
    best_pix_d  = best_pix_q;
    if (ctrl_i.clear) begin
      best_dist_d = '1;
      best_pix_d  = '0;
    end else if (ctrl_i.shift) begin
      best_pix_d  = pix_right_i;
    end else if (cand_a_q && (cur_dist < best_dist_q)) begin
      // strict less: the earlier index keeps a tie
      best_dist_d = cur_dist;
      best_pix_d  = pix_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_cand_q  <= 1'b0;
      fwd_last_q  <= 1'b0;
      cand_a_q    <= 1'b0;
      last_a_q    <= 1'b0;
      done_q      <= 1'b0;
      best_dist_q <= '1;
      best_pix_q  <= '0;
    end else begin
      fwd_cand_q  <= entry_i.cand;
      fwd_last_q  <= entry_i.last;
      cand_a_q    <= entry_i.cand;
      last_a_q    <= entry_i.last;
      done_q      <= last_a_q;
      best_dist_q <= best_dist_d;
      best_pix_q  <= best_pix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_color_q <= entry_i.color;
    fwd_pix_q   <= entry_i.pix;
    pix_a_q     <= entry_i.pix;
    sq_r_q      <= sq_diff(entry_i.color.red,   RefColor.red);
    sq_g_q      <= sq_diff(entry_i.color.green, RefColor.green);
    sq_b_q      <= sq_diff(entry_i.color.blue,  RefColor.blue);
  end

  assign entry_o = nps_pkg::entry_t'{fwd_cand_q, fwd_last_q, fwd_color_q, fwd_pix_q};
  assign pix_o   = best_pix_q;
  assign done_o  = done_q;

endmodule

@@ src/nearest_palette_color_search_top.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: red, green, blue; tlast: last entry
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: ref number, pixel, matched; tlast
//
// Cycles: during a run one colormap entry is taken per cycle. After the entry
// with tlast the input closes while that entry walks the cell chain (one cell per
// cycle, two stages inside each cell), then NUM_REFERENCES result items leave,
// one per cycle while m_axis_tready_i is high.
// Reset: asynchronous, active low; all cells start empty, entry index 0.
// Stalls: output backpressure holds the unload shift; input is closed until the
// last result item of the run is taken.

module nearest_palette_color_search_top #(
  parameter int NUM_REFERENCES = nps_pkg::NUM_REFERENCES,
  parameter int MAX_ENTRIES    = nps_pkg::MAX_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [15:0] entry_red, [31:16] entry_green,
                                        // [47:32] entry_blue
  input  logic        s_axis_tlast_i,   // last_entry
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [3:0] reference_number, [11:4] chosen_pixel,
                                        // [12] matched, [15:13] zero
  output logic        m_axis_tlast_o    // last_result
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int REF_W = (NUM_REFERENCES > 1) ? $clog2(NUM_REFERENCES) : 1;
  localparam int PW    = nps_pkg::PIX_W;
  localparam int RNW   = nps_pkg::REFN_W;
  localparam int CW    = nps_pkg::CHAN_W;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_UNLOAD
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;       // index of the next entry, saturating
  logic [REF_W-1:0] ref_q;       // reference being unloaded
  logic             any_match_q;

  logic            in_acc, out_acc, cand_idx, tail_done, ref_last;
  nps_pkg::entry_t head;
  nps_pkg::ctrl_t  ctrl;

  nps_pkg::entry_t         chain_entry [NUM_REFERENCES+1];
  logic [PW-1:0]           chain_pix   [NUM_REFERENCES+1];
  logic [NUM_REFERENCES-1:0] cell_done;

  assign s_axis_tready_o = (state_q == ST_RUN);
  assign m_axis_tvalid_o = (state_q == ST_UNLOAD);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // entry 0 never competes; nor do entries taken once the counter sits at its ceiling
  assign cand_idx = (cnt_q != '0) && (cnt_q != CNT_W'(MAX_ENTRIES));
  assign ref_last = (ref_q == REF_W'(NUM_REFERENCES - 1));

  assign head.cand        = in_acc && cand_idx;
  assign head.last        = in_acc && s_axis_tlast_i;
  assign head.color.red   = s_axis_tdata_i[CW-1:0];
  assign head.color.green = s_axis_tdata_i[2*CW-1:CW];
  assign head.color.blue  = s_axis_tdata_i[3*CW-1:2*CW];
  assign head.pix         = PW'(cnt_q);

  assign ctrl.shift = out_acc;
  assign ctrl.clear = out_acc && ref_last;

  // cell chain: entries flow toward the tail, results shift toward the head
  assign chain_entry[0]              = head;
  assign chain_pix[NUM_REFERENCES]   = '0;

  for (genvar r = 0; r < NUM_REFERENCES; r++) begin : g_cell
    nps_cell #(
      .REF_IDX (r)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .entry_i     (chain_entry[r]),
      .ctrl_i      (ctrl),
      .pix_right_i (chain_pix[r+1]),
      .entry_o     (chain_entry[r+1]),
      .pix_o       (chain_pix[r]),
      .done_o      (cell_done[r])
    );
  end

  // the tail cell's forwarded entry has no consumer; its done flag ends the drain
  assign tail_done = cell_done[NUM_REFERENCES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      ref_q       <= '0;
      any_match_q <= 1'b0;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (in_acc) begin
            if (cand_idx) begin
              any_match_q <= 1'b1;
            end
            if (s_axis_tlast_i) begin
              cnt_q   <= '0;
              state_q <= ST_DRAIN;
            end else if (cnt_q != CNT_W'(MAX_ENTRIES)) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (tail_done) begin
            ref_q   <= '0;
            state_q <= ST_UNLOAD;
          end
        end
        ST_UNLOAD: begin
          if (out_acc) begin
            if (ref_last) begin
              any_match_q <= 1'b0;
              state_q     <= ST_RUN;
            end else begin
              ref_q <= ref_q + REF_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  // head cell holds the result for the reference being unloaded
  assign m_axis_tdata_o[RNW-1:0]       = RNW'(ref_q);
  assign m_axis_tdata_o[RNW+PW-1:RNW]  = any_match_q ? chain_pix[0] : '0;
  assign m_axis_tdata_o[RNW+PW]        = any_match_q;
  assign m_axis_tdata_o[15:RNW+PW+1]   = '0;
  assign m_axis_tlast_o                = ref_last;

  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, s_axis_tready_o && m_axis_tvalid_o)
  `ASSERT_PROP(a_done_in_drain, clk_i, rst_ni, tail_done |-> (state_q == ST_DRAIN))
  `ASSERT_PROP(a_last_closes, clk_i, rst_ni, (in_acc && s_axis_tlast_i) |=> !s_axis_tready_o)
  `ASSERT_PROP(a_reopen, clk_i, rst_ni, (out_acc && m_axis_tlast_o) |=> (s_axis_tready_o && (cnt_q == '0)))

endmodule
